@@ hdl/qpn_pkg.sv @@
// ----------------------------------------------------------------------------
// qpn_pkg
// Shared types and constants for the quaternion product normalizer.
// ----------------------------------------------------------------------------
`default_nettype none
package qpn_pkg;

    // width of one quaternion component on the ports
    localparam int COMP_W = 16;
    // exact product component: 16x16 products, four summed
    localparam int PROD_W = 34;
    // magnitude of a product component
    localparam int MAG_W = 33;
    // scaled magnitudes lie below 2^30
    localparam int NORM_W = 30;
    // sum of four squares of 30-bit values
    localparam int SUM_W = 62;
    // integer square root width
    localparam int ROOT_W = 31;
    // shift amount to bring the largest magnitude into [2^29, 2^30)
    localparam int SHIFT_W = 6;

    typedef logic [MAG_W-1:0] mag_t;
    typedef logic [NORM_W-1:0] nmag_t;

    // sideband that rides along the pipeline with each transaction
    typedef struct packed {
        logic [3:0] neg;
        logic       zero;
    } side_t;

endpackage
`default_nettype wire

@@ hdl/quaternion_product_normalize.sv @@
// ----------------------------------------------------------------------------
// quaternion_product_normalize
// Hamilton product of two Q1.14 quaternions, normalized to unit length.
// ----------------------------------------------------------------------------
// One transaction enters per cycle and one leaves per cycle unless the output
// is held; each passes through the seven product, scaling and squaring stages,
// the 31 square-root cells (one root bit each), the 30 + FRAC_BITS + 1 divider
// cells (one numerator bit each, four lanes side by side) and the output
// register. The whole pipeline advances together and stalls only when the
// output is held.
// A zero product gives the identity quaternion with degenerate set.
`default_nettype none
module quaternion_product_normalize
    import qpn_pkg::*;
#(
    parameter int FRAC_BITS = 14
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // left_w, left_x, left_y, left_z, right_w, right_x, right_y, right_z
    input  wire logic [127:0] s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // out_w, out_x, out_y, out_z
    output logic [63:0]       m_tdata,
    // degenerate
    output logic              m_tuser
);

    localparam int NUM_W  = NORM_W + FRAC_BITS + 1;
    localparam int QUO_W  = FRAC_BITS + 1;
    localparam int DIV_N  = NUM_W;
    localparam int ONE    = 1 << FRAC_BITS;
    localparam int CLAMP  = (ONE > 32767) ? 32767 : ONE;

    logic en;
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    // stage 1: the sixteen products
    logic                     v1_reg;
    logic signed [31:0]       pr_reg [16];
    logic signed [COMP_W-1:0] l [4];
    logic signed [COMP_W-1:0] r [4];

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            l[i] = s_tdata[16*i +: 16];
            r[i] = s_tdata[64 + 16*i +: 16];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 4; i++)
            begin
                for (int j = 0; j < 4; j++)
                begin
                    pr_reg[4*i+j] <= l[i] * r[j];
                end
            end
        end
    end

    // stage 2: combine into the product components
    logic                     v2_reg;
    logic signed [PROD_W-1:0] p_reg [4];

    function automatic logic signed [PROD_W-1:0] ext(input logic signed [31:0] a);
        return PROD_W'(a);
    endfunction

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg[0] <= ext(pr_reg[0])  - ext(pr_reg[5])  - ext(pr_reg[10]) - ext(pr_reg[15]);
            p_reg[1] <= ext(pr_reg[1])  + ext(pr_reg[4])  + ext(pr_reg[11]) - ext(pr_reg[14]);
            p_reg[2] <= ext(pr_reg[2])  - ext(pr_reg[7])  + ext(pr_reg[8])  + ext(pr_reg[13]);
            p_reg[3] <= ext(pr_reg[3])  + ext(pr_reg[6])  - ext(pr_reg[9])  + ext(pr_reg[12]);
        end
    end

    // stage 3: sign and magnitude, largest magnitude
    logic  v3_reg;
    mag_t  m_reg [4];
    logic  [3:0] neg_reg;
    mag_t  mag3 [4];
    mag_t  or3;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            mag3[i] = p_reg[i][PROD_W-1] ? MAG_W'(-p_reg[i]) : MAG_W'(p_reg[i]);
        end
    end

    mag_t maxm_reg;
    mag_t max_a;
    mag_t max_b;

    always_comb
    begin
        max_a = (mag3[0] > mag3[1]) ? mag3[0] : mag3[1];
        max_b = (mag3[2] > mag3[3]) ? mag3[2] : mag3[3];
        or3   = (max_a > max_b) ? max_a : max_b;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_reg    <= mag3;
            maxm_reg <= or3;
            for (int i = 0; i < 4; i++)
            begin
                neg_reg[i] <= p_reg[i][PROD_W-1];
            end
        end
    end

    // stage 4: leading-one position of the largest magnitude
    logic                 v4_reg;
    mag_t                 m4_reg [4];
    side_t                side4_reg;
    logic [SHIFT_W-1:0]   lead;
    logic [SHIFT_W-1:0]   lead_reg;

    always_comb
    begin
        lead = '0;
        for (int b = 0; b < MAG_W; b++)
        begin
            if (maxm_reg[b])
            begin
                lead = SHIFT_W'(b);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m4_reg         <= m_reg;
            lead_reg       <= lead;
            side4_reg.neg  <= neg_reg;
            side4_reg.zero <= (maxm_reg == '0);
        end
    end

    // stage 5: scale so the leading one sits at bit 29
    logic                 v5_reg;
    nmag_t                n5_reg [4];
    side_t                side5_reg;
    logic [SUM_W-1:0]     sq_reg [4];
    nmag_t                n5 [4];

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            if (lead_reg >= SHIFT_W'(29))
            begin
                n5[i] = NORM_W'(m4_reg[i] >> (lead_reg - SHIFT_W'(29)));
            end
            else
            begin
                n5[i] = NORM_W'(m4_reg[i] << (SHIFT_W'(29) - lead_reg));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n5_reg    <= n5;
            side5_reg <= side4_reg;
        end
    end

    // stage 6: squares (30x30), stage 7: sum
    logic             v6_reg;
    nmag_t            n6_reg [4];
    side_t            side6_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 4; i++)
            begin
                sq_reg[i] <= SUM_W'(n5_reg[i] * n5_reg[i]);
            end
            n6_reg    <= n5_reg;
            side6_reg <= side5_reg;
        end
    end

    logic             v7_reg;
    logic [SUM_W-1:0] sum_reg;
    nmag_t            n7_reg [4];
    side_t            side7_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sum_reg   <= sq_reg[0] + sq_reg[1] + sq_reg[2] + sq_reg[3];
            n7_reg    <= n6_reg;
            side7_reg <= side6_reg;
        end
    end

    // valid pipe through the front stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
        end
    end

    // square-root chain
    logic              sv   [ROOT_W+1];
    logic [SUM_W-1:0]  srem [ROOT_W+1];
    logic [ROOT_W-1:0] sroot[ROOT_W+1];
    nmag_t             smag [ROOT_W+1][4];
    side_t             sside[ROOT_W+1];

    assign sv[0]    = v7_reg;
    assign srem[0]  = sum_reg;
    assign sroot[0] = '0;
    assign smag[0]  = n7_reg;
    assign sside[0] = side7_reg;

    for (genvar k = 0; k < ROOT_W; k++)
    begin : g_sqrt
        qpn_sqrt_cell #(.STEP(k)) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (sv[k]),
            .en        (en),
            .in_rem    (srem[k]),
            .in_root   (sroot[k]),
            .in_mag    (smag[k]),
            .in_side   (sside[k]),
            .out_valid (sv[k+1]),
            .out_rem   (srem[k+1]),
            .out_root  (sroot[k+1]),
            .out_mag   (smag[k+1]),
            .out_side  (sside[k+1])
        );
    end

    // divider chain: numerator m<<FRAC_BITS plus floor(r/2), quotient by r
    logic              dv   [DIV_N+1];
    logic [ROOT_W-1:0] dden [DIV_N+1];
    logic [ROOT_W:0]   drem [DIV_N+1][4];
    logic [NUM_W-1:0]  dnum [DIV_N+1][4];
    logic [QUO_W-1:0]  dquo [DIV_N+1][4];
    side_t             dside[DIV_N+1];
    logic [NUM_W-1:0]  num0 [4];
    logic [ROOT_W-1:0] den0;

    always_comb
    begin
        den0 = (sroot[ROOT_W] == '0) ? ROOT_W'(1) : sroot[ROOT_W];
        for (int i = 0; i < 4; i++)
        begin
            num0[i] = ({{(FRAC_BITS+1){1'b0}}, smag[ROOT_W][i]} << FRAC_BITS)
                    + NUM_W'(sroot[ROOT_W] >> 1);
            dnum[0][i] = num0[i];
            drem[0][i] = '0;
            dquo[0][i] = '0;
        end
    end

    assign dv[0]    = sv[ROOT_W];
    assign dden[0]  = den0;
    assign dside[0] = sside[ROOT_W];

    for (genvar k = 0; k < DIV_N; k++)
    begin : g_div
        qpn_div_cell #(.NUM_W(NUM_W), .QUO_W(QUO_W)) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (dv[k]),
            .en        (en),
            .in_den    (dden[k]),
            .in_rem    (drem[k]),
            .in_num    (dnum[k]),
            .in_quo    (dquo[k]),
            .in_side   (dside[k]),
            .out_valid (dv[k+1]),
            .out_den   (dden[k+1]),
            .out_rem   (drem[k+1]),
            .out_num   (dnum[k+1]),
            .out_quo   (dquo[k+1]),
            .out_side  (dside[k+1])
        );
    end

    // clamp, restore sign, output register
    logic [15:0] res [4];
    logic [15:0] cmag;

    always_comb
    begin
        cmag = '0;
        for (int i = 0; i < 4; i++)
        begin
            cmag = (dquo[DIV_N][i] > QUO_W'(CLAMP)) ? 16'(CLAMP) : 16'(dquo[DIV_N][i]);
            res[i] = dside[DIV_N].neg[i] ? 16'(-cmag) : cmag;
        end
        if (dside[DIV_N].zero)
        begin
            res[0] = 16'(CLAMP);
            res[1] = '0;
            res[2] = '0;
            res[3] = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid <= 1'b0;
        end
        else if (en)
        begin
            m_tvalid <= dv[DIV_N];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_tdata <= {res[3], res[2], res[1], res[0]};
            m_tuser <= dside[DIV_N].zero;
        end
    end

`ifndef SYNTHESIS
    // held output stays put
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && m_tvalid)
        else $error("output changed while stalled");
    // degenerate result is exactly the identity
    a_ident: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata == {48'd0, 16'(CLAMP)})
        else $error("degenerate result is not the identity");
    // stall propagates to input
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input accepted during stall");
`endif

endmodule
`default_nettype wire

@@ hdl/qpn_sqrt_cell.sv @@
// ----------------------------------------------------------------------------
// qpn_sqrt_cell
// One step of the restoring square root, one result bit per cell.
// ----------------------------------------------------------------------------
`default_nettype none
module qpn_sqrt_cell
    import qpn_pkg::*;
#(
    parameter int STEP = 0
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire logic              en,
    input  wire logic [SUM_W-1:0]  in_rem,
    input  wire logic [ROOT_W-1:0] in_root,
    input  wire nmag_t             in_mag [4],
    input  wire side_t             in_side,
    output logic                   out_valid,
    output logic [SUM_W-1:0]       out_rem,
    output logic [ROOT_W-1:0]      out_root,
    output nmag_t                  out_mag [4],
    output side_t                  out_side
);

    localparam int BITPOS = 2 * (ROOT_W - 1 - STEP);

    logic [SUM_W+1:0]  trial;
    logic [SUM_W+1:0]  rem_ext;
    logic [SUM_W-1:0]  rem_next;
    logic [ROOT_W-1:0] root_next;
    logic              fits;

    // trial subtract of (root<<2 | 1) at this bit position
    always_comb
    begin
        rem_ext   = {2'b00, in_rem};
        trial     = (({{(SUM_W+2-ROOT_W){1'b0}}, in_root} << 2) | (SUM_W+2)'(1)) << BITPOS;
        fits      = rem_ext >= trial;
        rem_next  = fits ? SUM_W'(rem_ext - trial) : in_rem;
        root_next = {in_root[ROOT_W-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid <= 1'b0;
        end
        else if (en)
        begin
            out_valid <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_rem  <= rem_next;
            out_root <= root_next;
            out_mag  <= in_mag;
            out_side <= in_side;
        end
    end

endmodule
`default_nettype wire

@@ hdl/qpn_div_cell.sv @@
// ----------------------------------------------------------------------------
// qpn_div_cell
// One step of a restoring divider over four lanes, one quotient bit per cell.
// ----------------------------------------------------------------------------
`default_nettype none
module qpn_div_cell
    import qpn_pkg::*;
#(
    parameter int NUM_W = 45,
    parameter int QUO_W = 15
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    input  wire logic                 en,
    input  wire logic [ROOT_W-1:0]    in_den,
    input  wire logic [ROOT_W:0]      in_rem [4],
    input  wire logic [NUM_W-1:0]     in_num [4],
    input  wire logic [QUO_W-1:0]     in_quo [4],
    input  wire side_t                in_side,
    output logic                      out_valid,
    output logic [ROOT_W-1:0]         out_den,
    output logic [ROOT_W:0]           out_rem [4],
    output logic [NUM_W-1:0]          out_num [4],
    output logic [QUO_W-1:0]          out_quo [4],
    output side_t                     out_side
);

    logic [ROOT_W:0]    shifted [4];
    logic [ROOT_W:0]    rem_next [4];
    logic [NUM_W-1:0]   num_next [4];
    logic [QUO_W-1:0]   quo_next [4];

    // shift in the next numerator bit, subtract when it fits
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            shifted[i]  = {in_rem[i][ROOT_W-1:0], in_num[i][NUM_W-1]};
            num_next[i] = {in_num[i][NUM_W-2:0], 1'b0};
            if (shifted[i] >= {1'b0, in_den})
            begin
                rem_next[i] = shifted[i] - {1'b0, in_den};
                quo_next[i] = {in_quo[i][QUO_W-2:0], 1'b1};
            end
            else
            begin
                rem_next[i] = shifted[i];
                quo_next[i] = {in_quo[i][QUO_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid <= 1'b0;
        end
        else if (en)
        begin
            out_valid <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_den  <= in_den;
            out_rem  <= rem_next;
            out_num  <= num_next;
            out_quo  <= quo_next;
            out_side <= in_side;
        end
    end

endmodule
`default_nettype wire
